FILE: hdl/pdmv_pkg.sv
// shared types and constants for the per-dimension mean and variance accumulator
package pdmv_pkg;

    localparam int SUM_W    = 40;
    localparam int SQ_W     = 56;
    localparam int OSQ_W    = 55;
    localparam int OCNT_W   = 24;
    localparam int DIM_W    = 6;
    localparam int SMP_W    = 16;
    localparam int VAR_W    = 30;
    localparam int SD_W     = 15;
    localparam int FCNT_W   = 24;
    localparam int CFG_W    = 7;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_REM   = 2'd1;
    localparam logic [1:0] REQ_MERGE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_UNDER = 2'd3;

    localparam logic [SQ_W-1:0] VAR_MAX = SQ_W'(30'h3FFF_FFFF);

    typedef struct packed {
        logic [1:0]              req_type;
        logic [DIM_W-1:0]        dim;
        logic signed [SMP_W-1:0] sample;
        logic [SUM_W-1:0]        other_sum;
        logic [OSQ_W-1:0]        other_sumsq;
        logic [OCNT_W-1:0]       other_count;
        logic                    last_of_frame;
        logic                    bad_dim;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: hdl/pdmv_front.sv
// input side: accepts beats, holds the dimension limit and checks the range
module pdmv_front
    import pdmv_pkg::*;
#(
    parameter int MAX_DIMS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [DIM_W-1:0]        i_dim,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic [SUM_W-1:0]        i_other_sum,
    input  logic [OSQ_W-1:0]        i_other_sumsq,
    input  logic [OCNT_W-1:0]       i_other_count,
    input  logic                    i_last_of_frame,
    input  t_q_status               i_q,
    output logic                    o_push,
    output t_entry                  o_entry
);

    logic [CFG_W-1:0] r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= CFG_W'(39);
        end else if (i_cfg_we) begin
            r_dims <= i_cfg_data;
        end
    end

    assign o_stall = i_q.full;
    assign o_push  = i_valid && !i_q.full;

    always_comb begin
        o_entry.req_type      = i_req_type;
        o_entry.dim           = i_dim;
        o_entry.sample        = i_sample;
        o_entry.other_sum     = i_other_sum;
        o_entry.other_sumsq   = i_other_sumsq;
        o_entry.other_count   = i_other_count;
        o_entry.last_of_frame = i_last_of_frame;
        o_entry.bad_dim       = ({1'b0, i_dim} >= r_dims) ||
                                (32'(i_dim) >= 32'(MAX_DIMS));
    end

endmodule

FILE: hdl/pdmv_fifo.sv
// two-entry queue between the input side and the execution side
module pdmv_fifo
    import pdmv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_q
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_q.full  = (r_cnt == 2'd2);
    assign o_q.empty = (r_cnt == 2'd0);

endmodule

FILE: hdl/pdmv_div.sv
// restoring divider, one quotient bit per cycle
module pdmv_div #(
    parameter int NW = 56,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   n_trial;
    logic          n_ge;

    assign n_trial = {r_rem, r_num[NW-1]};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], n_ge};
            r_rem <= n_ge ? DW'(n_trial - {1'b0, r_den}) : n_trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: hdl/pdmv_back.sv
// execution side: statistics stores, frame count, divide and square root
module pdmv_back
    import pdmv_pkg::*;
#(
    parameter int MAX_DIMS   = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_entry                  i_head,
    input  t_q_status               i_q,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic signed [SMP_W-1:0] o_mean,
    output logic [VAR_W-1:0]        o_variance,
    output logic [SD_W-1:0]         o_std_dev,
    output logic [FCNT_W-1:0]       o_frame_count
);

    localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIVM  = 3'd2;
    localparam logic [2:0] S_DIVV  = 3'd3;
    localparam logic [2:0] S_VAR   = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [SUM_W-1:0] mem_sum   [MAX_DIMS];
    logic [SQ_W-1:0]  mem_sumsq [MAX_DIMS];
    logic             r_vld     [MAX_DIMS];

    logic [2:0]              r_state;
    t_entry                  r_item;
    logic [SUM_W-1:0]        r_rd_sum;
    logic [SQ_W-1:0]         r_rd_sumsq;
    logic                    r_rd_vld;
    logic [COUNT_BITS-1:0]   r_frames;
    logic [1:0]              r_status;
    logic signed [SMP_W-1:0] r_mean;
    logic [VAR_W-1:0]        r_var;
    logic                    r_neg;
    logic [SQ_W-1:0]         r_e;
    logic [SQ_W-1:0]         r_m2;
    logic [31:0]             r_sq_v;
    logic [31:0]             r_sq_r;
    logic [31:0]             r_sq_bit;

    logic                    r_o_valid;
    logic [1:0]              r_o_status;
    logic signed [SMP_W-1:0] r_o_mean;
    logic [VAR_W-1:0]        r_o_var;
    logic [SD_W-1:0]         r_o_sd;
    logic [FCNT_W-1:0]       r_o_frames;

    logic [AW-1:0]           n_addr;
    logic [AW-1:0]           n_waddr;
    logic [SUM_W-1:0]        n_cur_sum;
    logic [SQ_W-1:0]         n_cur_sq;
    logic signed [31:0]      n_ssq;
    logic [SUM_W-1:0]        n_sext;
    logic [SUM_W-1:0]        n_sum;
    logic [SQ_W-1:0]         n_sumsq;
    logic                    n_we;
    logic [COUNT_BITS-1:0]   n_frames;
    logic [32:0]             n_csum;
    logic [SUM_W-1:0]        n_mag;
    logic [SQ_W-1:0]         n_num;
    logic signed [SMP_W-1:0] n_mean;
    logic [SQ_W-1:0]         n_dv;
    logic [31:0]             n_trial;
    logic                    n_load_out;

    logic                    div_start;
    logic [SQ_W-1:0]         div_num;
    logic                    div_busy;
    logic                    div_done;
    logic [SQ_W-1:0]         div_quot;

    assign o_pop      = (r_state == S_IDLE) && !i_q.empty;
    assign n_addr     = AW'(i_head.dim);
    assign n_waddr    = AW'(r_item.dim);
    assign n_load_out = (r_state == S_FIN) && (!r_o_valid || !i_stall);

    always_comb begin
        n_cur_sum = r_rd_vld ? r_rd_sum : '0;
        n_cur_sq  = r_rd_vld ? r_rd_sumsq : '0;
        n_ssq     = r_item.sample * r_item.sample;
        n_sext    = {{(SUM_W - SMP_W){r_item.sample[SMP_W-1]}}, r_item.sample};
        n_sum     = n_cur_sum;
        n_sumsq   = n_cur_sq;
        n_frames  = r_frames;
        n_we      = 1'b0;
        n_csum    = 33'(r_frames);
        case (r_item.req_type)
            REQ_ADD: begin
                n_we    = !r_item.bad_dim;
                n_sum   = n_cur_sum + n_sext;
                n_sumsq = n_cur_sq + SQ_W'(unsigned'(n_ssq));
                n_csum  = 33'(r_frames) + 33'(1);
            end
            REQ_REM: begin
                n_we    = !r_item.bad_dim && (r_frames != '0);
                n_sum   = n_cur_sum - n_sext;
                n_sumsq = n_cur_sq - SQ_W'(unsigned'(n_ssq));
            end
            REQ_MERGE: begin
                n_we    = !r_item.bad_dim;
                n_sum   = n_cur_sum + r_item.other_sum;
                n_sumsq = n_cur_sq + SQ_W'(r_item.other_sumsq);
                n_csum  = 33'(r_frames) + 33'(r_item.other_count);
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
        if (n_we && r_item.last_of_frame) begin
            if (r_item.req_type == REQ_REM) begin
                n_frames = r_frames - COUNT_BITS'(1);
            end else begin
                n_frames = (n_csum >= 33'(CMAX)) ? CMAX : COUNT_BITS'(n_csum);
            end
        end
    end

    always_comb begin
        n_mag = n_cur_sum[SUM_W-1] ? SUM_W'(0) - n_cur_sum : n_cur_sum;
        n_num = SQ_W'(n_mag) + SQ_W'(r_frames >> 1);
        if (r_neg) begin
            n_mean = (div_quot > SQ_W'(32768)) ? -16'sd32768
                                               : signed'(16'(16'd0 - div_quot[15:0]));
        end else begin
            n_mean = (div_quot > SQ_W'(32767)) ? 16'sd32767 : signed'(div_quot[15:0]);
        end
        n_dv    = (r_e > r_m2) ? r_e - r_m2 : '0;
        n_trial = r_sq_r + r_sq_bit;
    end

    assign div_start = ((r_state == S_EXEC) && (r_item.req_type == REQ_READ) &&
                        !r_item.bad_dim && (r_frames != '0)) ||
                       ((r_state == S_DIVM) && div_done);
    assign div_num   = (r_state == S_EXEC) ? n_num : n_cur_sq;

    pdmv_div #(
        .NW(SQ_W),
        .DW(COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_frames),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_head.bad_dim) begin
            r_rd_sum   <= mem_sum[n_addr];
            r_rd_sumsq <= mem_sumsq[n_addr];
        end
        if ((r_state == S_EXEC) && n_we) begin
            mem_sum[n_waddr]   <= n_sum;
            mem_sumsq[n_waddr] <= n_sumsq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld  <= 1'b0;
            r_state   <= S_IDLE;
            r_frames  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rd_vld <= !i_head.bad_dim && r_vld[n_addr];
            end
            if ((r_state == S_EXEC) && n_we) begin
                r_vld[n_waddr] <= 1'b1;
            end
            if (r_state == S_EXEC) begin
                r_frames <= n_frames;
            end
            if (n_load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= div_start ? S_DIVM : S_FIN;
                end
                S_DIVM: begin
                    if (div_done) begin
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (div_done) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sq_bit == 32'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        case (r_state)
            S_EXEC: begin
                r_mean   <= '0;
                r_var    <= '0;
                r_sq_r   <= '0;
                r_neg    <= n_cur_sum[SUM_W-1];
                r_status <= ST_OK;
                if (r_item.bad_dim) begin
                    r_status <= ST_RANGE;
                end else if ((r_item.req_type == REQ_REM) && (r_frames == '0)) begin
                    r_status <= ST_UNDER;
                end else if ((r_item.req_type == REQ_READ) && (r_frames == '0)) begin
                    r_status <= ST_EMPTY;
                end
            end
            S_DIVM: begin
                if (div_done) begin
                    r_mean <= n_mean;
                end
            end
            S_DIVV: begin
                if (div_done) begin
                    r_e  <= div_quot;
                    r_m2 <= SQ_W'(unsigned'(32'(r_mean * r_mean)));
                end
            end
            S_VAR: begin
                r_var    <= (n_dv > VAR_MAX) ? VAR_MAX[VAR_W-1:0] : n_dv[VAR_W-1:0];
                r_sq_v   <= (n_dv > VAR_MAX) ? 32'(VAR_MAX) : 32'(n_dv);
                r_sq_r   <= '0;
                r_sq_bit <= 32'h4000_0000;
            end
            S_SQRT: begin
                if (r_sq_v >= n_trial) begin
                    r_sq_v <= r_sq_v - n_trial;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            default: begin
            end
        endcase
        if (n_load_out) begin
            r_o_status <= r_status;
            r_o_mean   <= r_mean;
            r_o_var    <= r_var;
            r_o_sd     <= r_sq_r[SD_W-1:0];
            r_o_frames <= FCNT_W'(r_frames);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_mean        = r_o_mean;
    assign o_variance    = r_o_var;
    assign o_std_dev     = r_o_sd;
    assign o_frame_count = r_o_frames;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && !i_q.empty)
        else $error("pop outside idle or from empty queue");

    a_update_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && (r_item.req_type != REQ_READ) |=> (r_state == S_FIN))
        else $error("update did not finish in one cycle");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (r_status == ST_RANGE) |->
        (r_mean == '0) && (r_var == '0) && (r_sq_r == '0))
        else $error("range error with nonzero statistics");

    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) && (r_sq_bit == 32'd1) |=> (r_state == S_FIN))
        else $error("square root did not end");

endmodule

FILE: hdl/per_dim_mean_variance_accumulator_top.sv
// top level of the per-dimension mean and variance accumulator
//
// input channel: i_valid / o_stall, one beat per request (add, remove,
// merge, read) on one dimension. output channel: o_valid / i_stall, one
// result beat per request, in order.
// i_cfg_we / i_cfg_data write the number of dimensions in use; write only
// while the block is idle.
// a small queue sits between the input check and the execution unit, so
// the input keeps taking beats while a result waits to be taken.
// add, remove and merge pass from accept to result as follows: pop the
// queue and read the store, update, then register the result. read runs
// two 56-bit one-bit-per-cycle divisions in the shared divider (mean,
// then mean of squares), then a 16-step square root. the divider sets
// the read rate.
// reset clears the sums, sums of squares (valid bits), the frame count and
// sets the dimension limit to 39.
// while i_stall is high the result beat holds; the queue then fills and
// o_stall rises.
module per_dim_mean_variance_accumulator_top
    import pdmv_pkg::*;
#(
    parameter int MAX_DIMS   = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [DIM_W-1:0]        i_dim,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic [SUM_W-1:0]        i_other_sum,
    input  logic [OSQ_W-1:0]        i_other_sumsq,
    input  logic [OCNT_W-1:0]       i_other_count,
    input  logic                    i_last_of_frame,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic signed [SMP_W-1:0] o_mean,
    output logic [VAR_W-1:0]        o_variance,
    output logic [SD_W-1:0]         o_std_dev,
    output logic [FCNT_W-1:0]       o_frame_count
);

    t_q_status q_status;
    t_entry    push_entry;
    t_entry    head_entry;
    logic      push;
    logic      pop;

    pdmv_front #(
        .MAX_DIMS(MAX_DIMS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_dim           (i_dim),
        .i_sample        (i_sample),
        .i_other_sum     (i_other_sum),
        .i_other_sumsq   (i_other_sumsq),
        .i_other_count   (i_other_count),
        .i_last_of_frame (i_last_of_frame),
        .i_q             (q_status),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    pdmv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_q     (q_status)
    );

    pdmv_back #(
        .MAX_DIMS   (MAX_DIMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_entry),
        .i_q           (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_mean        (o_mean),
        .o_variance    (o_variance),
        .o_std_dev     (o_std_dev),
        .o_frame_count (o_frame_count)
    );

endmodule

FILE: verif/tb.sv
// self-checking testbench for the per-dimension mean and variance accumulator
module tb;
    import pdmv_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [1:0]              i_req_type;
    logic [DIM_W-1:0]        i_dim;
    logic signed [SMP_W-1:0] i_sample;
    logic [SUM_W-1:0]        i_other_sum;
    logic [OSQ_W-1:0]        i_other_sumsq;
    logic [OCNT_W-1:0]       i_other_count;
    logic                    i_last_of_frame;
    logic                    o_valid;
    logic                    i_stall;
    logic [1:0]              o_status;
    logic signed [SMP_W-1:0] o_mean;
    logic [VAR_W-1:0]        o_variance;
    logic [SD_W-1:0]         o_std_dev;
    logic [FCNT_W-1:0]       o_frame_count;

    per_dim_mean_variance_accumulator_top u_dut (.*);

    typedef struct packed {
        logic [1:0]        status;
        logic [SMP_W-1:0]  mean;
        logic [VAR_W-1:0]  variance;
        logic [SD_W-1:0]   std_dev;
        logic [FCNT_W-1:0] frame_count;
    } t_stats;

    localparam logic [FCNT_W-1:0] CNT_MAX = '1;
    localparam int IDLE_LIMIT = 20000;

    logic [SUM_W-1:0]  acc_sum [64];
    logic [SQ_W-1:0]   acc_sq [64];
    logic [FCNT_W-1:0] acc_count;
    logic [CFG_W-1:0]  acc_dims;
    t_stats            pending_stats[$];
    int                error_count;
    int                idle_cycles;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [SD_W-1:0] isqrt_var(logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[SD_W-1:0];
    endfunction

    function automatic logic [FCNT_W-1:0] count_sat_add(logic [FCNT_W-1:0] a,
                                                         logic [FCNT_W-1:0] b);
        logic [FCNT_W:0] s;
        s = a + b;
        return s[FCNT_W] || s[FCNT_W-1:0] == CNT_MAX ? CNT_MAX : s[FCNT_W-1:0];
    endfunction

    function automatic t_stats predict_stats(logic [1:0] req, logic [5:0] d,
                                             logic signed [15:0] s, logic [39:0] osum,
                                             logic [54:0] osq, logic [23:0] ocnt,
                                             logic last);
        t_stats r;
        logic signed [39:0] sm;
        logic [39:0] mag;
        logic [39:0] q;
        logic signed [17:0] m;
        logic [55:0] e;
        logic [55:0] m2;
        logic [55:0] dv;
        logic [55:0] sq;
        r = '0;
        sq = 56'(32'(s * s));
        if (d >= acc_dims) begin
            r.status = ST_RANGE;
        end else if (req == REQ_ADD) begin
            acc_sum[d] = acc_sum[d] + 40'(s);
            acc_sq[d] = acc_sq[d] + sq;
            if (last) acc_count = count_sat_add(acc_count, FCNT_W'(1));
        end else if (req == REQ_REM) begin
            if (acc_count == 0) begin
                r.status = ST_UNDER;
            end else begin
                acc_sum[d] = acc_sum[d] - 40'(s);
                acc_sq[d] = acc_sq[d] - sq;
                if (last) acc_count = acc_count - FCNT_W'(1);
            end
        end else if (req == REQ_MERGE) begin
            acc_sum[d] = acc_sum[d] + osum;
            acc_sq[d] = acc_sq[d] + 56'(osq);
            if (last) acc_count = count_sat_add(acc_count, ocnt);
        end else if (acc_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            sm = acc_sum[d];
            mag = sm < 0 ? -sm : sm;
            q = (mag + 40'(acc_count / 2)) / 40'(acc_count);
            if (sm < 0) m = q > 32768 ? -18'sd32768 : -$signed(18'(q));
            else m = q > 32767 ? 18'sd32767 : $signed(18'(q));
            e = acc_sq[d] / 56'(acc_count);
            m2 = 56'(m * m);
            dv = e > m2 ? e - m2 : 0;
            if (dv > VAR_MAX) dv = VAR_MAX;
            r.mean = m[15:0];
            r.variance = dv[29:0];
            r.std_dev = isqrt_var(dv[31:0]);
        end
        r.frame_count = acc_count;
        return r;
    endfunction

    task automatic send_beat(logic [1:0] req, logic [5:0] d, logic [15:0] s,
                             logic [39:0] osum, logic [54:0] osq, logic [23:0] ocnt,
                             logic last);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_valid = 1;
        i_req_type = req;
        i_dim = d;
        i_sample = s;
        i_other_sum = osum;
        i_other_sumsq = osq;
        i_other_count = ocnt;
        i_last_of_frame = last;
        do @(posedge i_clk); while (o_stall);
        pending_stats.push_back(predict_stats(req, d, s, osum, osq, ocnt, last));
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic set_dims(logic [6:0] n);
        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_data = n;
        @(negedge i_clk);
        i_cfg_we = 0;
        acc_dims = n;
    endtask

    task automatic rand_beat(int dmax);
        logic [1:0] req;
        req = 2'($urandom_range(0, 3));
        send_beat(req, 6'($urandom_range(0, dmax)), 16'($urandom),
                  40'({$urandom, $urandom} >>
                      ($urandom_range(0, 1) ? 0 : $urandom_range(8, 30))),
                  55'({$urandom, $urandom} >> $urandom_range(9, 40)),
                  24'($urandom_range(0, 1) ? $urandom_range(0, 5) : {$urandom}),
                  1'($urandom_range(0, 2) == 0));
    endtask

    task automatic test_directed();
        send_beat(REQ_READ, 0, 0, 0, 0, 0, 0);
        send_beat(REQ_REM, 1, 16'h7fff, 0, 0, 0, 1);
        send_beat(REQ_ADD, 63, 16'h8000, 0, 0, 0, 1);
        send_beat(REQ_ADD, 38, 16'h8000, 0, 0, 0, 1);
        send_beat(REQ_ADD, 38, 16'h7fff, 0, 0, 0, 1);
        send_beat(REQ_READ, 38, 0, 0, 0, 0, 0);
        send_beat(REQ_ADD, 0, 16'h7fff, 0, 0, 0, 0);
        send_beat(REQ_READ, 0, 0, 0, 0, 0, 0);
        send_beat(REQ_REM, 0, 16'h7fff, 0, 0, 0, 1);
        send_beat(REQ_MERGE, 2, 0, 40'h80_0000_0000, '1, 24'hffffff, 1);
        send_beat(REQ_READ, 2, 0, 0, 0, 0, 0);
        send_beat(REQ_MERGE, 3, 0, 40'h7f_ffff_ffff, 55'h1, 24'h1, 1);
        send_beat(REQ_READ, 3, 0, 0, 0, 0, 0);
        send_beat(REQ_MERGE, 4, 0, '1, 55'h0, 0, 0);
        send_beat(REQ_READ, 4, 0, 0, 0, 0, 0);
        send_beat(REQ_ADD, 39, 16'h1234, 0, 0, 0, 1);
    endtask

    task automatic test_small_frames();
        int k;
        int j;
        for (k = 0; k < 100; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                rand_beat(acc_dims + 2);
            end else begin
                for (j = 0; j < 3; j++)
                    send_beat($urandom_range(0, 1) ? REQ_ADD : REQ_REM, 6'(j),
                              16'($urandom), 0, 0, 0, j == 2);
                send_beat(REQ_READ, 6'($urandom_range(0, 3)), 0, 0, 0, 0, 0);
            end
        end
    endtask

    task automatic test_random(int n, int dmax);
        repeat (n) rand_beat(dmax);
    endtask

    always @(posedge i_clk) begin
        t_stats got;
        t_stats exp_stats;
        if (o_valid && !i_stall) begin
            got = {o_status, o_mean, o_variance, o_std_dev, o_frame_count};
            if (pending_stats.size() == 0) begin
                $display("%0t unexpected beat %h", $time, got);
                error_count++;
            end else begin
                exp_stats = pending_stats.pop_front();
                if (got !== exp_stats) begin
                    $display("%0t mismatch exp %h got %h", $time, exp_stats, got);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                i_stall = 1;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
                i_stall = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_valid = 0;
        i_req_type = 0;
        i_dim = 0;
        i_sample = 0;
        i_other_sum = 0;
        i_other_sumsq = 0;
        i_other_count = 0;
        i_last_of_frame = 0;
        for (int k = 0; k < 64; k++) begin
            acc_sum[k] = 0;
            acc_sq[k] = 0;
        end
        acc_count = 0;
        acc_dims = 39;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_small_frames();
        set_dims(7'd64);
        test_random(200, 63);
        set_dims(7'd1);
        test_random(60, 3);
        set_dims(7'd127);
        test_random(60, 63);
        set_dims(7'd0);
        test_random(20, 63);
        set_dims(7'd10);
        test_random(100, 12);
        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (error_count == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule
